// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Defining ASSERT_OFF empties
// every macro.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFFS_W = 11;
  localparam int CODE_W = 8;
  localparam int NIB_W  = 4;
  localparam int CELL_W = 16;
  // Linear cell address before range check: 31 * 127 + 127 fits in 13 bits
  localparam int LIN_W  = 13;

  // Blank cell: white on black space
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // Character codes handled by put
  localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_LAST  = 8'h7F;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_SET   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_t;

  // Captured command
  typedef struct packed {
    logic [1:0]        mode;
    logic [CODE_W-1:0] char_code;
    logic [NIB_W-1:0]  background;
    logic [NIB_W-1:0]  foreground;
    logic [COL_W-1:0]  set_col;
    logic [ROW_W-1:0]  set_row;
  } item_t;

  // Outcome of one put
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              scroll;
    logic              cell_we;
    logic [LIN_W-1:0]  cell_addr;
    logic [CELL_W-1:0] cell_data;
  } put_res_t;

  // Requests to the screen store
  typedef struct packed {
    logic              put_we;
    logic [LIN_W-1:0]  put_addr;
    logic [CELL_W-1:0] put_data;
    logic              sweep_start;
    logic              sweep_copy;
  } mem_cmd_t;

endpackage

// File: src/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console: a ROWS x COLUMNS cell store and a cursor, driven by put,
// clear and set-cursor commands; each command reports the cursor.
//
//   port group  direction  transfer
//   ----------  ---------  ----------------------------------------------
//   in_*        input      start high while busy low, one command
//   out_*       output     out_valid high for one cycle, one result
//
// Put, set cursor and the unused mode run one execute state and return to
// idle, busy high meanwhile. Clear and a put that scrolls run the sweep
// engine over every cell through the store's one write port, with busy
// high until it is done. After reset a fill pass runs with busy high.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_mode,
  input  logic [tcw_pkg::CODE_W-1:0] in_char_code,
  input  logic [tcw_pkg::NIB_W-1:0]  in_background,
  input  logic [tcw_pkg::NIB_W-1:0]  in_foreground,
  input  logic [tcw_pkg::COL_W-1:0]  in_set_col,
  input  logic [tcw_pkg::ROW_W-1:0]  in_set_row,
  output logic                       out_valid,
  output logic [tcw_pkg::COL_W-1:0]  out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]  out_cursor_row,
  output logic [tcw_pkg::OFFS_W-1:0] out_cursor_offset,
  output logic                       out_scrolled
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = ROWS * COLUMNS;

  state_t            state_r, state_nxt;
  item_t             item_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [OFFS_W-1:0] out_offs_r, out_offs_nxt;
  logic              out_scrolled_r, out_scrolled_nxt;
  logic              out_load;
  logic [LIN_W-1:0]  offs_full;

  put_res_t          put_res;
  mem_cmd_t          mem_cmd;
  logic              sweep_done;

  // Cursor arithmetic of a put
  tcw_put_step #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_put_step (
    .col        (col_r),
    .row        (row_r),
    .char_code  (item_r.char_code),
    .background (item_r.background),
    .foreground (item_r.foreground),
    .res        (put_res)
  );

  // Cell store and sweep engine
  tcw_screen_mem #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_screen_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (mem_cmd),
    .sweep_done (sweep_done)
  );

  assign busy = (state_r != ST_IDLE);

  // Command capture
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= '{mode: in_mode, char_code: in_char_code, background: in_background,
                  foreground: in_foreground, set_col: in_set_col, set_row: in_set_row};
    end
  end

  // Sequencer: next state, cursor and store requests
  always_comb begin
    state_nxt        = state_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    out_valid_nxt    = 1'b0;
    out_scrolled_nxt = 1'b0;
    out_load         = 1'b0;
    mem_cmd          = '0;

    unique case (state_r)
      ST_INIT: begin
        if (sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_load = 1'b1;
        unique case (mode_t'(item_r.mode))
          MODE_PUT: begin
            col_nxt          = put_res.col;
            row_nxt          = put_res.row;
            out_scrolled_nxt = put_res.scroll;
            mem_cmd.put_we   = put_res.cell_we;
            mem_cmd.put_addr = put_res.cell_addr;
            mem_cmd.put_data = put_res.cell_data;
            if (put_res.scroll) begin
              mem_cmd.sweep_start = 1'b1;
              mem_cmd.sweep_copy  = 1'b1;
            end
          end
          MODE_CLEAR: begin
            col_nxt             = '0;
            row_nxt             = '0;
            mem_cmd.sweep_start = 1'b1;
          end
          MODE_SET: begin
            col_nxt = item_r.set_col;
            row_nxt = item_r.set_row;
          end
          default: ;
        endcase
        if (mem_cmd.sweep_start) begin
          state_nxt = ST_SWEEP;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (sweep_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase

    offs_full    = LIN_W'(row_nxt) * LIN_W'(COLUMNS) + LIN_W'(col_nxt);
    out_offs_nxt = offs_full[OFFS_W-1:0];
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Cursor and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, held until the next command executes
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_col_r      <= col_nxt;
      out_row_r      <= row_nxt;
      out_offs_r     <= out_offs_nxt;
      out_scrolled_r <= out_scrolled_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_col    = out_col_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_offset = out_offs_r;
  assign out_scrolled      = out_scrolled_r;

  // Checks
  `ASSERT_ALWAYS(a_put_addr_in_store, clk, rst_n, !mem_cmd.put_we || (mem_cmd.put_addr < LIN_W'(CELL_COUNT)), "put write beyond the cell store")
  `ASSERT_ALWAYS(a_put_only_in_exec, clk, rst_n, !mem_cmd.put_we || (state_r == ST_EXEC), "cell write outside command execution")
  `ASSERT_NEXT(a_short_cmd_result, clk, rst_n, (state_r == ST_EXEC) && !mem_cmd.sweep_start, out_valid && (state_r == ST_IDLE), "short command gave no result")
  `ASSERT_ALWAYS(a_result_source, clk, rst_n, !out_valid || $past((state_r == ST_EXEC) || sweep_done), "result strobe without finished command")

endmodule

// File: src/tcw_put_step.sv
// ----------------------------------------------------------------------------
// tcw_put_step
// Cursor arithmetic of one put: control codes, cell address, wrap and the
// decision to scroll.
// ----------------------------------------------------------------------------
module tcw_put_step #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic [tcw_pkg::COL_W-1:0]  col,
  input  logic [tcw_pkg::ROW_W-1:0]  row,
  input  logic [tcw_pkg::CODE_W-1:0] char_code,
  input  logic [tcw_pkg::NIB_W-1:0]  background,
  input  logic [tcw_pkg::NIB_W-1:0]  foreground,
  output tcw_pkg::put_res_t          res
);
  import tcw_pkg::*;

  // Enough tab stops to pass the widest column value
  localparam int STOPS      = (1 << COL_W) / TAB_STOP + 1;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  logic [COL_W:0]   tab_col;
  logic [COL_W:0]   col_ctl;
  logic [COL_W:0]   col_adv;
  logic [ROW_W:0]   row_ctl;
  logic [ROW_W:0]   row_wrap;
  logic             printable;
  logic             wrap;
  logic [LIN_W-1:0] lin_addr;

  // Next tab stop: smallest multiple of TAB_STOP above the column
  always_comb begin
    tab_col = '0;
    for (int k = STOPS; k >= 1; k--) begin
      if ((COL_W+1)'(k * TAB_STOP) > {1'b0, col}) begin
        tab_col = (COL_W+1)'(k * TAB_STOP);
      end
    end
  end

  // Control codes
  always_comb begin
    col_ctl = {1'b0, col};
    row_ctl = {1'b0, row};
    unique case (char_code)
      CH_BS: begin
        if (col != '0) begin
          col_ctl = {1'b0, col} - (COL_W+1)'(1);
        end
      end
      CH_TAB: col_ctl = tab_col;
      CH_CR:  col_ctl = '0;
      CH_LF: begin
        col_ctl = '0;
        row_ctl = {1'b0, row} + (ROW_W+1)'(1);
      end
      default: ;
    endcase
  end

  // Printable write, then wrap and scroll
  always_comb begin
    printable = (char_code >= CH_SPACE) && (char_code <= CH_LAST);
    lin_addr  = LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
    col_adv   = printable ? col_ctl + (COL_W+1)'(1) : col_ctl;
    wrap      = col_adv >= (COL_W+1)'(COLUMNS);
    row_wrap  = wrap ? row_ctl + (ROW_W+1)'(1) : row_ctl;

    res.scroll    = row_wrap >= (ROW_W+1)'(ROWS);
    res.row       = res.scroll ? ROW_W'(ROWS - 1) : row_wrap[ROW_W-1:0];
    res.col       = wrap ? '0 : col_adv[COL_W-1:0];
    res.cell_we   = printable && (lin_addr < LIN_W'(CELL_COUNT));
    res.cell_addr = lin_addr;
    res.cell_data = {background, foreground, char_code};
  end

endmodule

// File: src/tcw_screen_mem.sv
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen cell store with its sweep engine. A sweep walks every cell once:
// in copy mode each cell takes the one a line below (scroll), and cells of
// the last line, or all cells in fill mode, take the blank value.
// ----------------------------------------------------------------------------
module tcw_screen_mem #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcw_pkg::mem_cmd_t cmd,
  output logic              sweep_done
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int KEEP_CELLS = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  logic [CELL_W-1:0] mem [CELL_COUNT];

  logic              active_r;
  logic              copy_r;
  logic [ADDR_W-1:0] cnt_r;
  logic              pend_valid_r;
  logic              pend_copy_r;
  logic              pend_last_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic [CELL_W-1:0] rd_data_r;

  logic [ADDR_W:0]   rd_addr;
  logic              rd_en;
  logic              last_issue;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;

  // Read one line ahead of the write pointer
  always_comb begin
    rd_addr    = {1'b0, cnt_r} + (ADDR_W+1)'(COLUMNS);
    rd_en      = active_r && copy_r && (rd_addr < (ADDR_W+1)'(CELL_COUNT));
    last_issue = cnt_r == ADDR_W'(CELL_COUNT - 1);
  end

  // Sweep control; reset starts a fill pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b1;
      copy_r       <= 1'b0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= active_r;
      if (cmd.sweep_start) begin
        active_r <= 1'b1;
        copy_r   <= cmd.sweep_copy;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + ADDR_W'(1);
        if (last_issue) begin
          active_r <= 1'b0;
        end
      end
    end
  end

  // Pending write stage, lines up with the read data
  always_ff @(posedge clk) begin
    pend_addr_r <= cnt_r;
    pend_copy_r <= copy_r && ({1'b0, cnt_r} < (ADDR_W+1)'(KEEP_CELLS));
    pend_last_r <= last_issue;
  end

  assign sweep_done = pend_valid_r & pend_last_r;

  // Single write port: sweep or put, never both
  always_comb begin
    wr_en   = pend_valid_r | cmd.put_we;
    wr_addr = pend_valid_r ? pend_addr_r : cmd.put_addr[ADDR_W-1:0];
    if (pend_valid_r) begin
      wr_data = pend_copy_r ? rd_data_r : BLANK_CELL;
    end else begin
      wr_data = cmd.put_data;
    end
  end

  // Store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

endmodule

// File: dv/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer. Put, clear and set-cursor
// commands are queued up front and sent by a clocked driver. Each transfer is
// run through a cursor tracker, and the cursor report it should produce is
// queued. A clocked monitor checks each result against the oldest report
// due. Cell contents never reach the ports, so only the cursor is tracked.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;

  // Mode code with no command behind it
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int NUM_CMDS     = 1775;
  localparam int SWEEP_BUDGET = 250;
  localparam int IDLE_PCT     = 23;
  localparam int QUIET_FROM   = 700;
  localparam int QUIET_TO     = 1000;
  localparam int TAIL_CYCLES  = ROWS * COLUMNS + 100;

  typedef struct {
    item_t cmd;
    bit    drain;
  } cmd_slot_t;

  typedef struct {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [OFFS_W-1:0] offset;
    logic              scrolled;
  } cursor_report_t;

  logic              clk               = 1'b0;
  logic              rst_n             = 1'b0;
  logic              start             = 1'b0;
  logic              busy;
  logic [1:0]        in_mode           = '0;
  logic [CODE_W-1:0] in_char_code      = '0;
  logic [NIB_W-1:0]  in_background     = '0;
  logic [NIB_W-1:0]  in_foreground     = '0;
  logic [COL_W-1:0]  in_set_col        = '0;
  logic [ROW_W-1:0]  in_set_row        = '0;
  logic              out_valid;
  logic [COL_W-1:0]  out_cursor_col;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [OFFS_W-1:0] out_cursor_offset;
  logic              out_scrolled;

  cmd_slot_t      cmds_to_send[$];
  cursor_report_t cursor_reports_due[$];
  item_t          cmd_on_bus;

  // Cursor as the checker sees it, and as the command planner sees it
  int unsigned tracked_col  = 0;
  int unsigned tracked_row  = 0;
  int unsigned plan_col     = 0;
  int unsigned plan_row     = 0;
  int          sweeps_left  = SWEEP_BUDGET;
  int          queued_count = 0;
  int          sent_count   = 0;
  int          fails        = 0;

  text_console_writer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_char_code     (in_char_code),
    .in_background    (in_background),
    .in_foreground    (in_foreground),
    .in_set_col       (in_set_col),
    .in_set_row       (in_set_row),
    .out_valid        (out_valid),
    .out_cursor_col   (out_cursor_col),
    .out_cursor_row   (out_cursor_row),
    .out_cursor_offset(out_cursor_offset),
    .out_scrolled     (out_scrolled)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Moves the cursor as one command does; returns 1 when the screen scrolls
  function automatic bit advance_cursor(inout int unsigned col, inout int unsigned row,
                                        input item_t c);
    bit scroll = 1'b0;
    case (c.mode)
      MODE_PUT: begin
        if (c.char_code == CH_BS && col != 0) begin
          col--;
        end else if (c.char_code == CH_TAB) begin
          col = (col / TAB_STOP + 1) * TAB_STOP;
        end else if (c.char_code == CH_CR) begin
          col = 0;
        end else if (c.char_code == CH_LF) begin
          col = 0;
          row++;
        end
        // printable codes advance; the cell write itself is not visible
        if (c.char_code >= CH_SPACE && c.char_code <= CH_LAST) begin
          col++;
        end
        if (col >= COLUMNS) begin
          col = 0;
          row++;
        end
        if (row >= ROWS) begin
          row    = ROWS - 1;
          scroll = 1'b1;
        end
      end
      MODE_CLEAR: begin
        col = 0;
        row = 0;
      end
      MODE_SET: begin
        col = 32'(c.set_col);
        row = 32'(c.set_row);
      end
      default: begin
      end
    endcase
    return scroll;
  endfunction

  function automatic item_t random_cmd(logic [1:0] m);
    item_t c;
    c.mode       = m;
    c.char_code  = CODE_W'($urandom);
    c.background = NIB_W'($urandom);
    c.foreground = NIB_W'($urandom);
    c.set_col    = COL_W'($urandom);
    c.set_row    = ROW_W'($urandom);
    return c;
  endfunction

  // Mostly printable text, with the handled controls and some junk codes
  function automatic logic [CODE_W-1:0] pick_char();
    int r = $urandom_range(99);
    if (r < 70) return CODE_W'($urandom_range(CH_LAST, CH_SPACE));
    if (r < 90) begin
      case ($urandom_range(3))
        0:       return CH_BS;
        1:       return CH_TAB;
        2:       return CH_CR;
        default: return CH_LF;
      endcase
    end
    if (r < 95) return CODE_W'($urandom_range(CH_SPACE - 1, 0));
    return CODE_W'($urandom_range(8'hFF, 8'h80));
  endfunction

  // Each clear or scroll costs a full sweep; past the budget, such a command
  // becomes a plain cursor move
  task automatic queue_cmd(item_t c, bit drain);
    int unsigned col;
    int unsigned row;
    bit          scroll;
    col    = plan_col;
    row    = plan_row;
    scroll = advance_cursor(col, row, c);
    if (scroll || c.mode == MODE_CLEAR) begin
      if (sweeps_left == 0) begin
        c.mode    = MODE_SET;
        c.set_col = COL_W'($urandom_range(COLUMNS - 1));
        c.set_row = ROW_W'($urandom_range(ROWS - 2));
        col       = 32'(c.set_col);
        row       = 32'(c.set_row);
      end else begin
        sweeps_left--;
      end
    end
    plan_col = col;
    plan_row = row;
    cmds_to_send.push_back('{c, drain});
    queued_count++;
  endtask

  task automatic send_put(logic [CODE_W-1:0] code, bit drain);
    item_t c;
    c           = random_cmd(MODE_PUT);
    c.char_code = code;
    queue_cmd(c, drain);
  endtask

  task automatic send_set(int unsigned col, int unsigned row);
    item_t c;
    c         = random_cmd(MODE_SET);
    c.set_col = COL_W'(col);
    c.set_row = ROW_W'(row);
    queue_cmd(c, 1'b0);
  endtask

  // Driver: holds a command until it is taken, then decides on the next one
  always @(posedge clk) begin : drive_cmds
    bit             scroll;
    bit             hold_off;
    cmd_slot_t      slot;
    cursor_report_t rep;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        scroll       = advance_cursor(tracked_col, tracked_row, cmd_on_bus);
        rep.col      = COL_W'(tracked_col);
        rep.row      = ROW_W'(tracked_row);
        rep.offset   = OFFS_W'(tracked_row * COLUMNS + tracked_col);
        rep.scrolled = scroll;
        cursor_reports_due.push_back(rep);
        sent_count++;
      end
      hold_off = 1'b1;
      if (cmds_to_send.size() != 0) begin
        hold_off = cmds_to_send[0].drain && cursor_reports_due.size() != 0;
        if (!hold_off && (sent_count < QUIET_FROM || sent_count >= QUIET_TO)) begin
          hold_off = $urandom_range(99) < IDLE_PCT;
        end
      end
      if (!(start && busy)) begin
        if (!hold_off) begin
          slot          = cmds_to_send.pop_front();
          cmd_on_bus    = slot.cmd;
          in_mode       <= slot.cmd.mode;
          in_char_code  <= slot.cmd.char_code;
          in_background <= slot.cmd.background;
          in_foreground <= slot.cmd.foreground;
          in_set_col    <= slot.cmd.set_col;
          in_set_row    <= slot.cmd.set_row;
          start         <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result strobe against the oldest report due
  always @(posedge clk) begin : check_reports
    cursor_report_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (cursor_reports_due.size() == 0) begin
        $error("result with no command outstanding: col %0d row %0d", out_cursor_col,
               out_cursor_row);
        fails++;
      end else begin
        want = cursor_reports_due.pop_front();
        if (out_cursor_col !== want.col) begin
          $error("cursor_col: expected %0d, got %0d", want.col, out_cursor_col);
          fails++;
        end
        if (out_cursor_row !== want.row) begin
          $error("cursor_row: expected %0d, got %0d", want.row, out_cursor_row);
          fails++;
        end
        if (out_cursor_offset !== want.offset) begin
          $error("cursor_offset: expected %0d, got %0d", want.offset, out_cursor_offset);
          fails++;
        end
        if (out_scrolled !== want.scrolled) begin
          $error("scrolled: expected %0d, got %0d", want.scrolled, out_scrolled);
          fails++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    item_t c;
    int    r;
    int    n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Attribute extremes and the code range edges
    c = random_cmd(MODE_PUT);
    c.char_code  = 8'h41;
    c.background = 4'hF;
    c.foreground = 4'h0;
    queue_cmd(c, 1'b0);
    c = random_cmd(MODE_PUT);
    c.char_code  = CH_SPACE;
    c.background = 4'h0;
    c.foreground = 4'hF;
    queue_cmd(c, 1'b0);
    send_put(CH_LAST, 1'b0);
    send_put(8'h80, 1'b0);
    send_put(8'hFF, 1'b0);
    send_put(8'h00, 1'b0);
    send_put(CODE_W'(CH_SPACE - 1), 1'b0);
    // backspace mid-line, then at column zero
    send_put(CH_BS, 1'b0);
    send_set(0, 0);
    send_put(CH_BS, 1'b0);
    send_put(CH_TAB, 1'b0);
    // tab from the last column wraps
    send_set(COLUMNS - 1, 0);
    send_put(CH_TAB, 1'b0);
    send_put(CH_CR, 1'b0);
    send_put(CH_LF, 1'b0);
    // wrap on the bottom row scrolls, as does newline there
    send_set(COLUMNS - 1, ROWS - 1);
    send_put(8'h5A, 1'b0);
    send_set(0, ROWS - 1);
    send_put(CH_LF, 1'b0);
    // cursor far outside the screen: offset overflows, write is dropped
    send_set(127, 31);
    send_put(8'h78, 1'b0);
    // an unhandled control below the screen still scrolls
    send_set(5, 30);
    send_put(8'h07, 1'b0);
    queue_cmd(random_cmd(MODE_CLEAR), 1'b0);
    queue_cmd(random_cmd(MODE_UNUSED), 1'b1);

    // Random part: mostly text runs from a placed cursor
    while (queued_count < NUM_CMDS) begin
      r = $urandom_range(99);
      if (r < 75) begin
        send_set($urandom_range(COLUMNS - 1), $urandom_range(ROWS - 1));
        n = $urandom_range(24, 1);
        repeat (n) send_put(pick_char(), 1'b0);
      end else if (r < 87) begin
        queue_cmd(random_cmd(2'($urandom_range(3))), 1'b0);
      end else if (r < 95) begin
        c = random_cmd(MODE_SET);
        if ($urandom_range(1)) c.set_col = COL_W'($urandom_range(127, COLUMNS));
        else c.set_row = ROW_W'($urandom_range(31, ROWS));
        queue_cmd(c, 1'b0);
        n = $urandom_range(3, 1);
        repeat (n) send_put(pick_char(), 1'b0);
      end else if (r < 98) begin
        queue_cmd(random_cmd(MODE_CLEAR), 1'b0);
      end else begin
        send_put(pick_char(), 1'b1);
      end
    end

    while (cmds_to_send.size() != 0 || start || cursor_reports_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("tb_text_console_writer passed");
    end else begin
      $display("tb_text_console_writer failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("tb_text_console_writer failed");
    $finish;
  end

endmodule
